// File: hw/rtl/bba_pkg.sv
// shared types, codes and defaults for the bitmap block allocator
package bba_pkg;

   localparam int DEF_BLOCKS      = 128;
   localparam int DEF_BLOCK_BYTES = 4096;

   localparam logic [31:0] HEAP_BASE_RESET = 32'h0000_D000;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FAIL    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   localparam int MAP_BITS = 32;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] alloc_size;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_address;
      logic [7:0]  used_count;
      logic [7:0]  free_count;
      logic [7:0]  total_count;
   } rsp_type;

endpackage

// File: hw/rtl/bitmap_block_allocator.sv
// bitmap block allocator top level: request sequencer, counters and result register
// allocate: a read state and a check state per bitmap word scanned (1 to MAP_WORDS), then the done state
// free: shift of heap offset to block index, then one read-modify-write
// statistics, zero size and ignored frees: straight to the done state; one request in flight, next beat
//   taken the cycle after the result is loaded; loading waits while an older result waits on rsp_ready
// reset: synchronous, map reads all free through per-word flags, used count zero, base 0xD000
module bitmap_block_allocator #(
   parameter int BLOCKS      = bba_pkg::DEF_BLOCKS,
   parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   localparam int MAP_WORDS = (BLOCKS + 31) / 32;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IX_W      = WORD_W + 5;
   localparam int CNT_W     = $clog2(BLOCKS + 1);
   localparam logic [32:0] HEAP_LIMIT = 33'(BLOCKS) * 33'(BLOCK_BYTES);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_SCAN_CHK = 3'd2;
   localparam logic [2:0] ST_DIV      = 3'd3;
   localparam logic [2:0] ST_FREE_RD  = 3'd4;
   localparam logic [2:0] ST_FREE_CHK = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   // bits of a word that stand for real blocks
   function automatic logic [31:0] live_mask(input logic [WORD_W-1:0] w);
      logic [31:0] m;
      logic [4:0]  b5;
      m = '0;
      for (int b = 0; b < 32; b++) begin
         b5   = 5'(b);
         m[b] = 32'({w, b5}) < 32'(BLOCKS);
      end
      return m;
   endfunction

   function automatic logic [4:0] lowest_set(input logic [31:0] v);
      logic [4:0] pos;
      pos = '0;
      for (int b = 31; b >= 0; b--) begin
         if (v[b]) begin
            pos = 5'(b);
         end
      end
      return pos;
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [31:0]       heap_base_ff;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [IX_W-1:0]   index_ff, index_in;
   logic [1:0]        status_ff, status_in;
   logic              alloc_ok_ff, alloc_ok_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   bba_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic [31:0]       offset;
   logic              free_ok;
   logic              div_start;
   logic              div_done;
   logic [IX_W-1:0]   div_quotient;

   logic              rd_en;
   logic [WORD_W-1:0] rd_addr;
   logic [31:0]       rd_data;
   logic              wr_en;
   logic [WORD_W-1:0] wr_addr;
   logic [31:0]       wr_data;

   logic [31:0]       avail;
   logic [4:0]        free_pos;
   logic [4:0]        clr_pos;
   logic              rsp_slot_free;
   logic [31:0]       used32;
   logic [31:0]       block_offset;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign offset    = req_data.free_address - heap_base_ff;
   assign free_ok   = (req_data.free_address != '0) && ({1'b0, offset} < HEAP_LIMIT);
   assign div_start = accept && (req_data.mode == bba_pkg::MODE_FREE) && free_ok;

   assign avail    = ~rd_data & live_mask(word_ff);
   assign free_pos = lowest_set(avail);
   assign clr_pos  = index_ff[4:0];

   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;
   assign used32        = 32'(used_ff);
   assign block_offset  = 32'(index_ff) * 32'(BLOCK_BYTES);

   always_comb begin
      rd_en   = (state_ff == ST_SCAN_RD) || (state_ff == ST_FREE_RD);
      rd_addr = (state_ff == ST_FREE_RD) ? index_ff[IX_W-1:5] : word_ff;
      wr_en   = 1'b0;
      wr_addr = word_ff;
      wr_data = rd_data;

      state_in     = state_ff;
      word_in      = word_ff;
      index_in     = index_ff;
      status_in    = status_ff;
      alloc_ok_in  = alloc_ok_ff;
      used_in      = used_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in   = bba_pkg::STATUS_DONE;
               alloc_ok_in = 1'b0;
               word_in     = '0;
               if (req_data.mode == bba_pkg::MODE_ALLOC) begin
                  if (req_data.alloc_size != '0) begin
                     state_in = ST_SCAN_RD;
                  end else begin
                     status_in = bba_pkg::STATUS_FAIL;
                     state_in  = ST_DONE;
                  end
               end else if (req_data.mode == bba_pkg::MODE_FREE) begin
                  if (free_ok) begin
                     state_in = ST_DIV;
                  end else begin
                     status_in = bba_pkg::STATUS_IGNORED;
                     state_in  = ST_DONE;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (avail != '0) begin
               wr_en             = 1'b1;
               wr_addr           = word_ff;
               wr_data           = rd_data;
               wr_data[free_pos] = 1'b1;
               used_in           = used_ff + 1'b1;
               index_in          = {word_ff, free_pos};
               alloc_ok_in       = 1'b1;
               state_in          = ST_DONE;
            end else if (word_ff == WORD_W'(MAP_WORDS - 1)) begin
               status_in = bba_pkg::STATUS_FAIL;
               state_in  = ST_DONE;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               index_in = div_quotient;
               state_in = ST_FREE_RD;
            end
         end
         ST_FREE_RD: begin
            state_in = ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            // clearing an already free block changes nothing
            if (rd_data[clr_pos]) begin
               wr_en            = 1'b1;
               wr_addr          = index_ff[IX_W-1:5];
               wr_data          = rd_data;
               wr_data[clr_pos] = 1'b0;
               used_in          = used_ff - 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_slot_free) begin
               rsp_data_in.status        = status_ff;
               rsp_data_in.block_address = alloc_ok_ff ? (heap_base_ff + block_offset) : '0;
               rsp_data_in.used_count    = used32[7:0];
               rsp_data_in.free_count    = 8'(32'(BLOCKS) - used32);
               rsp_data_in.total_count   = 8'(BLOCKS);
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= bba_pkg::HEAP_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            heap_base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      index_ff    <= index_in;
      status_ff   <= status_in;
      alloc_ok_ff <= alloc_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   bba_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WORD_W)
   ) u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bba_index_div #(
      .IX_W        (IX_W),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_index_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/bba_map_ram.sv
// in-use bitmap memory, one read and one write port, per-word fill flags
module bba_map_ram #(
   parameter int DEPTH  = 4,
   parameter int ADDR_W = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [bba_pkg::MAP_BITS-1:0]  rd_data,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [bba_pkg::MAP_BITS-1:0]  wr_data
);

   logic [bba_pkg::MAP_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]             written_ff;
   logic [bba_pkg::MAP_BITS-1:0] rd_data_ff;
   logic                         rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a word never written since reset reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_written_ff <= 1'b0;
      end else if (rd_en) begin
         rd_written_ff <= written_ff[rd_addr] | (wr_en && (wr_addr == rd_addr));
      end
   end

   // same-word write forwards into the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

// File: hw/rtl/bba_index_div.sv
// offset to block index: registered shift of the heap offset by the block size
module bba_index_div #(
   parameter int IX_W        = 7,
   parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [31:0]     dividend,
   output logic            done,
   output logic [IX_W-1:0] quotient
);

   // block size is a power of two, so the divide is a shift
   localparam int SHIFT = $clog2(BLOCK_BYTES);

   logic [IX_W-1:0] quo_ff, quo_in;
   logic            done_ff, done_in;
   logic [31:0]     shifted;

   assign shifted = dividend >> SHIFT;
   assign quo_in  = start ? shifted[IX_W-1:0] : quo_ff;
   assign done_in = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: tb/sv/allocator_checker.sv
// result checker for the bitmap block allocator: shadows the bitmap and compares every response
module allocator_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bba_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bba_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data,
   output int               results_due,
   output int               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import bba_pkg::*;

   localparam int BLOCKS      = DEF_BLOCKS;
   localparam int BLOCK_BYTES = DEF_BLOCK_BYTES;

   logic [BLOCKS-1:0] block_taken;
   int                blocks_used;
   logic [31:0]       heap_base_now;
   rsp_type           owed_results[$];
   int                mismatch_total = 0;

   assign fail_count = mismatch_total;

   task automatic note_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
      mismatch_total++;
   endtask

   // applies one request to the shadow bitmap and returns the response it must produce
   function automatic rsp_type serve_request(req_type r);
      rsp_type     o;
      logic [31:0] offset;
      int          slot;
      o = '0;
      o.status = STATUS_DONE;
      if (r.mode == MODE_ALLOC) begin
         slot = -1;
         if (r.alloc_size != 32'd0) begin
            for (int i = 0; i < BLOCKS; i++) begin
               if (!block_taken[i]) begin
                  slot = i;
                  break;
               end
            end
         end
         if (slot < 0) begin
            o.status = STATUS_FAIL;
         end else begin
            block_taken[slot] = 1'b1;
            blocks_used++;
            o.block_address = heap_base_now + 32'(slot) * 32'(BLOCK_BYTES);
         end
      end else if (r.mode == MODE_FREE) begin
         offset = r.free_address - heap_base_now;
         // address zero is never released, even inside the heap
         if (r.free_address == 32'd0 || 64'(offset) >= 64'(BLOCKS) * 64'(BLOCK_BYTES)) begin
            o.status = STATUS_IGNORED;
         end else begin
            slot = int'(offset / 32'(BLOCK_BYTES));
            if (block_taken[slot]) begin
               block_taken[slot] = 1'b0;
               blocks_used--;
            end
         end
      end
      o.used_count  = 8'(blocks_used);
      o.free_count  = 8'(BLOCKS - blocks_used);
      o.total_count = 8'(BLOCKS);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         block_taken   = '0;
         blocks_used   = 0;
         heap_base_now = HEAP_BASE_RESET;
         owed_results.delete();
      end else begin
         if (csr_wr_en)
            heap_base_now = csr_wr_data;
         if (req_valid && req_ready)
            owed_results.push_back(serve_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               note_mismatch("response beat with nothing owed", rsp_data.block_address, 32'd0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.status !== want.status)
                  note_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.block_address !== want.block_address)
                  note_mismatch("block_address", rsp_data.block_address, want.block_address);
               if (rsp_data.used_count !== want.used_count)
                  note_mismatch("used_count", 32'(rsp_data.used_count), 32'(want.used_count));
               if (rsp_data.free_count !== want.free_count)
                  note_mismatch("free_count", 32'(rsp_data.free_count), 32'(want.free_count));
               if (rsp_data.total_count !== want.total_count)
                  note_mismatch("total_count", 32'(rsp_data.total_count),
                                32'(want.total_count));
            end
         end
      end
      results_due <= owed_results.size();
   end

endmodule

// File: tb/sv/testbench.sv
// top of the allocator testbench: clock, reset, request stimulus, response back-pressure, verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bba_pkg::*;

   localparam int          PERIOD       = 20;
   localparam int          BLOCKS       = DEF_BLOCKS;
   localparam int          BLOCK_BYTES  = DEF_BLOCK_BYTES;
   localparam logic [31:0] HEAP_SPAN    = 32'(BLOCKS * BLOCK_BYTES);
   localparam logic [1:0]  MODE_STATS   = 2'd2;
   localparam logic [1:0]  MODE_SPARE   = 2'd3;
   localparam int          STALL_CYCLES = 300;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          PHASES       = 6;
   localparam int          PHASE_ITEMS  = 270;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int          results_due;
   int          fail_count;
   int          cycle_count  = 0;
   int          stall_asked  = 0;
   int          stall_served = 0;
   logic        calm         = 1'b0;
   logic [31:0] heap_now     = HEAP_BASE_RESET;

   always #(PERIOD / 2) clock = ~clock;

   bitmap_block_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   allocator_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .results_due (results_due),
      .fail_count  (fail_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random back-pressure plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_asked != stall_served) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < STALL_CYCLES; n++)
               @(posedge clock);
            stall_served++;
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 23);
      end
   end

   function automatic req_type make_req(logic [1:0] mode, logic [31:0] size, logic [31:0] addr);
      req_type r;
      r.mode         = mode;
      r.alloc_size   = size;
      r.free_address = addr;
      return r;
   endfunction

   // holds the request beat until taken, then idles at random unless calm
   task automatic offer(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      while (!calm && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic set_heap_base(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      heap_now     = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // alternating fill and drain bursts so the map runs full and empty again
   task automatic run_mix(input int count);
      int          left;
      int          burst;
      int          alloc_pct;
      int          pick;
      bit          filling;
      req_type     r;
      filling = 1'b1;
      left    = count;
      while (left > 0) begin
         burst     = $urandom_range(20, 160);
         alloc_pct = filling ? 85 : 25;
         while (burst > 0 && left > 0) begin
            pick = $urandom_range(0, 99);
            r    = make_req(MODE_ALLOC, $urandom, $urandom);
            if (pick < 5) begin
               r.mode = pick[0] ? MODE_SPARE : MODE_STATS;
            end else if (pick < 5 + alloc_pct) begin
               if ($urandom_range(0, 19) == 0)
                  r.alloc_size = 32'd0;
            end else begin
               r.mode = MODE_FREE;
               case ($urandom_range(0, 19))
                  0: r.free_address = 32'd0;
                  1: ;
                  2: r.free_address = heap_now - 32'($urandom_range(1, BLOCK_BYTES));
                  3: r.free_address = heap_now + HEAP_SPAN + 32'($urandom_range(0, BLOCK_BYTES));
                  default: r.free_address = heap_now
                        + 32'($urandom_range(0, BLOCKS - 1)) * 32'(BLOCK_BYTES)
                        + 32'($urandom_range(0, BLOCK_BYTES - 1));
               endcase
            end
            offer(r);
            burst--;
            left--;
         end
         filling = !filling;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: statistics, zero size, edges of the heap, double free
      offer(make_req(MODE_STATS, 32'd0, 32'd0));
      offer(make_req(MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      offer(make_req(MODE_ALLOC, 32'd0, 32'd0));
      offer(make_req(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0));
      offer(make_req(MODE_ALLOC, 32'd1, 32'd0));
      offer(make_req(MODE_FREE, 32'd0, 32'd0));
      offer(make_req(MODE_FREE, 32'd0, heap_now - 32'd1));
      offer(make_req(MODE_FREE, 32'd0, heap_now + HEAP_SPAN));
      offer(make_req(MODE_FREE, 32'd0, heap_now + HEAP_SPAN - 32'd1));
      offer(make_req(MODE_FREE, 32'd0, heap_now + 32'(BLOCK_BYTES) + 32'd5));
      offer(make_req(MODE_FREE, 32'd0, heap_now + 32'(BLOCK_BYTES) + 32'd5));
      offer(make_req(MODE_ALLOC, 32'h8000_0000, 32'd0));
      offer(make_req(MODE_FREE, 32'd0, 32'hFFFF_FFFF));

      // heap at address zero: a free of zero stays ignored, block zero comes back as zero
      settle();
      set_heap_base(32'd0);
      offer(make_req(MODE_FREE, 32'd0, 32'd0));
      offer(make_req(MODE_FREE, 32'd0, 32'd1));
      offer(make_req(MODE_ALLOC, 32'd7, 32'd0));
      offer(make_req(MODE_STATS, 32'd0, 32'd0));

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: set_heap_base(32'hFFFF_F000);
            1: set_heap_base(32'h1234_5679);
            2: set_heap_base(32'hFFFF_FFFF);
            3: set_heap_base(32'h0009_F000);
            4: set_heap_base(32'h0000_0000);
            default: set_heap_base(HEAP_BASE_RESET);
         endcase
         calm <= (p == 3);
         if (p == 1)
            stall_asked <= stall_asked + 1;
         run_mix(PHASE_ITEMS);
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_map_ram.sv
hw/rtl/bba_index_div.sv
hw/rtl/bitmap_block_allocator.sv
tb/sv/allocator_checker.sv
tb/sv/testbench.sv
